// ----- rtl/srms_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the sparse row matrix store.
// Depends on nothing; every other file refers to it by scoped names.
package srms_pkg;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int COL_BITS_DEF    = 10;
  localparam logic [6:0] ROWS_RESET = 7'd64;

  localparam logic [1:0] ACT_READ = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_ADD  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         row;
    logic [9:0]         col;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               hit;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    item_t item;
    logic  out_of_range;
  } job_t;

endpackage

// ----- rtl/srms_front.sv -----
`timescale 1ns / 1ps
// Front part: holds the row limit register and classifies each incoming item.
// Depends on srms_pkg.
module srms_front #(
  parameter int MAX_ROWS = srms_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  srms_pkg::item_t    item,
  output logic               q_push,
  output srms_pkg::job_t     q_job,
  input  logic               q_full
);

  logic [6:0] rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= srms_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      rows_in_use <= cfg_data;
    end
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_job.item         = item;
    q_job.out_of_range = ({1'b0, item.row} >= rows_in_use) ||
                         (32'(item.row) >= 32'(MAX_ROWS));
  end

endmodule

// ----- rtl/srms_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue that decouples the front part from the back part.
// Depends on srms_pkg.
module srms_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  srms_pkg::job_t wdata,
  output logic           full,
  input  logic           rd,
  output srms_pkg::job_t rdata,
  output logic           empty
);

  srms_pkg::job_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ----- rtl/srms_back.sv -----
`timescale 1ns / 1ps
// Back part: searches a row, then reads, updates or inserts the entry, bumps row starts.
// Depends on srms_pkg; holds the entry and row start memories.
module srms_back #(
  parameter int MAX_ROWS    = srms_pkg::MAX_ROWS_DEF,
  parameter int MAX_ENTRIES = srms_pkg::MAX_ENTRIES_DEF,
  parameter int COL_BITS    = srms_pkg::COL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  srms_pkg::job_t   q_job,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output srms_pkg::result_t result
);

  localparam int EB  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CB  = $clog2(MAX_ENTRIES + 1);
  localparam int RB  = $clog2(MAX_ROWS + 1);
  localparam int RIB = $clog2(MAX_ROWS + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_RS0, S_RS1, S_SRCH, S_SRCHW, S_CHK, S_SHIFT, S_SHEND, S_BUMP, S_RESULT
  } state_t;

  state_t state;

  logic [COL_BITS-1:0] col_mem [MAX_ENTRIES];
  logic [31:0]         val_mem [MAX_ENTRIES];
  logic [CB-1:0]       rs_mem  [MAX_ROWS+1];
  logic [MAX_ROWS:0]   rs_valid;

  logic [COL_BITS-1:0] col_rd;
  logic [31:0]         val_rd;
  logic [CB-1:0]       rs_rd;
  logic [RB-1:0]       rs_ra_q;
  logic [CB-1:0]       rs_eff;

  srms_pkg::item_t     cur;
  logic [COL_BITS-1:0] key;
  logic [CB-1:0]       count;
  logic [CB-1:0]       lo;
  logic [CB-1:0]       hi;
  logic [CB-1:0]       hio;
  logic [CB-1:0]       mid;
  logic [CB-1:0]       mid_q;
  logic [CB-1:0]       idx;
  logic [EB-1:0]       wa;
  logic                pend;
  logic [RIB-1:0]      ri;
  logic [RB-1:0]       rwa;
  srms_pkg::result_t   res;
  logic                out_full;
  logic                res_load;

  logic          ent_we;
  logic [EB-1:0] ent_wa;
  logic [EB-1:0] ent_ra;
  logic [COL_BITS-1:0] ent_wcol;
  logic [31:0]   ent_wval;
  logic          rs_we;
  logic [RB-1:0] rs_wa;
  logic [RB-1:0] rs_ra;
  logic [CB-1:0] h_clip;
  logic [32:0]   sum;
  logic [31:0]   sat;
  logic [31:0]   chk_val;
  logic [31:0]   col_w;
  logic          found;

  assign col_w    = 32'(cur.col);
  assign key      = col_w[COL_BITS-1:0];
  assign rs_eff   = rs_valid[rs_ra_q] ? rs_rd : '0;
  assign mid      = lo + ((hi - lo) >> 1);
  assign h_clip   = (rs_eff > count) ? count : rs_eff;
  assign sum      = {val_rd[31], val_rd} + {cur.value[31], cur.value};
  assign found    = (lo < hio) && (col_rd == key);
  assign res_load = (state == S_RESULT) && (!out_full || pop);

  always_comb begin
    case (sum[32:31])
      2'b01:   sat = 32'h7FFF_FFFF;
      2'b10:   sat = 32'h8000_0000;
      default: sat = sum[31:0];
    endcase
  end

  always_comb begin
    case (cur.action)
      srms_pkg::ACT_SET: chk_val = cur.value;
      srms_pkg::ACT_ADD: chk_val = sat;
      default:           chk_val = val_rd;
    endcase
  end

  always_comb begin
    ent_we   = 1'b0;
    ent_wa   = wa;
    ent_wcol = col_rd;
    ent_wval = val_rd;
    ent_ra   = lo[EB-1:0];
    rs_we    = 1'b0;
    rs_wa    = rwa;
    rs_ra    = RB'(cur.row);
    q_pop    = 1'b0;
    case (state)
      S_IDLE: begin
        q_pop = !q_empty;
        rs_ra = RB'(q_job.item.row);
      end
      S_RS0: rs_ra = RB'(cur.row) + RB'(1);
      S_SRCH: begin
        if (lo < hi) ent_ra = mid[EB-1:0];
      end
      S_CHK: begin
        if (found && (cur.action == srms_pkg::ACT_SET || cur.action == srms_pkg::ACT_ADD)) begin
          ent_we   = 1'b1;
          ent_wa   = lo[EB-1:0];
          ent_wcol = key;
          ent_wval = (cur.action == srms_pkg::ACT_SET) ? cur.value : sat;
        end
      end
      S_SHIFT: begin
        ent_we = pend;
        ent_ra = EB'(idx - CB'(1));
      end
      S_SHEND: begin
        ent_we   = 1'b1;
        ent_wa   = lo[EB-1:0];
        ent_wcol = key;
        ent_wval = cur.value;
      end
      S_BUMP: begin
        rs_we = pend;
        rs_ra = ri[RB-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      col_mem[ent_wa] <= ent_wcol;
      val_mem[ent_wa] <= ent_wval;
    end
    col_rd <= col_mem[ent_ra];
    val_rd <= val_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= rs_eff + CB'(1);
    end
    rs_rd   <= rs_mem[rs_ra];
    rs_ra_q <= rs_ra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_valid <= '0;
    end else if (rs_we) begin
      rs_valid[rs_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      out_full <= 1'b0;
      pend     <= 1'b0;
    end else begin
      if (res_load) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_job.item;
            res <= '{read_value: '0, hit: 1'b0,
                     status: q_job.out_of_range ? srms_pkg::ST_RANGE : srms_pkg::ST_OK};
            if (q_job.out_of_range) begin
              state <= S_RESULT;
            end else begin
              state <= S_RS0;
            end
          end
        end
        S_RS0: begin
          lo    <= rs_eff;
          state <= S_RS1;
        end
        S_RS1: begin
          hi    <= h_clip;
          hio   <= h_clip;
          if (lo > h_clip) lo <= h_clip;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid_q <= mid;
            state <= S_SRCHW;
          end else begin
            state <= S_CHK;
          end
        end
        S_SRCHW: begin
          if (col_rd < key) lo <= mid_q + CB'(1);
          else hi <= mid_q;
          state <= S_SRCH;
        end
        S_CHK: begin
          if (found) begin
            res   <= '{read_value: chk_val, hit: 1'b1, status: srms_pkg::ST_OK};
            state <= S_RESULT;
          end else if (cur.action == srms_pkg::ACT_SET || cur.action == srms_pkg::ACT_ADD) begin
            if (32'(count) >= 32'(MAX_ENTRIES)) begin
              res.status <= srms_pkg::ST_FULL;
              state      <= S_RESULT;
            end else begin
              idx   <= count;
              pend  <= 1'b0;
              state <= S_SHIFT;
            end
          end else begin
            state <= S_RESULT;
          end
        end
        S_SHIFT: begin
          if (idx > lo) begin
            wa   <= idx[EB-1:0];
            idx  <= idx - CB'(1);
            pend <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_SHEND;
          end
        end
        S_SHEND: begin
          count          <= count + CB'(1);
          res.read_value <= cur.value;
          ri             <= RIB'(cur.row) + RIB'(1);
          pend           <= 1'b0;
          state          <= S_BUMP;
        end
        S_BUMP: begin
          if (32'(ri) <= 32'(MAX_ROWS)) begin
            rwa  <= ri[RB-1:0];
            ri   <= ri + RIB'(1);
            pend <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_load) begin
            result <= res;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !out_full;

endmodule

// ----- rtl/sparse_row_matrix_store.sv -----
`timescale 1ns / 1ps
// Top level of the sparse row matrix store: front classifier, queue, back executor.
// Depends on srms_pkg, srms_front, srms_queue and srms_back.
//
//   channel   signals                 transfer when
//   input     push, full, item        push && !full
//   result    empty, pop, result      pop && !empty
//   config    cfg_we, cfg_data        cfg_we
//
// A read or an update fetches the row's two starts, then binary-searches the row in the back part.
// An insert then shifts the later entries up, one entry per cycle, and bumps every later row start.
// Reset is synchronous and leaves an empty matrix; no clearing pass is needed.
// The two-entry queue and the result register let either side stall on its own.
module sparse_row_matrix_store #(
  parameter int MAX_ROWS    = srms_pkg::MAX_ROWS_DEF,
  parameter int MAX_ENTRIES = srms_pkg::MAX_ENTRIES_DEF,
  parameter int COL_BITS    = srms_pkg::COL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  srms_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output srms_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  srms_pkg::job_t q_in;
  srms_pkg::job_t q_out;

  srms_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full), .item(item),
    .q_push(q_push), .q_job(q_in), .q_full(q_full)
  );

  srms_queue u_queue (
    .clk(clk), .rst(rst), .wr(q_push), .wdata(q_in), .full(q_full),
    .rd(q_pop), .rdata(q_out), .empty(q_empty)
  );

  srms_back #(
    .MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES), .COL_BITS(COL_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_job(q_out), .q_pop(q_pop),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule
